/* sv/wfs_pkg.sv */
package wfs_pkg;

	localparam int DEF_WIN_W     = 3;
	localparam int DEF_WIN_H     = 3;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT    = 1024;

	// column field in a queued job, wide enough for the longest line allowed
	localparam int COL_W       = 12;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_TF_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FEAT_0       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FEAT_1       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FEAT_2       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FEAT_3       = 3'd6;

	localparam logic [1:0] MODE_LINEAR    = 2'd0;
	localparam logic [1:0] MODE_ELLIPTIC  = 2'd1;
	localparam logic [1:0] MODE_GAUSSIAN  = 2'd2;
	localparam logic [1:0] MODE_HYPERBOLA = 2'd3;

	typedef logic [3:0][63:0] feat_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [COL_W-1:0]   col;
		logic [1:0]         rm;     // row modulo window height
		logic [9:0]         c0;
		logic [9:0]         r0;
		logic               emit;
		logic               last;
	} job_t;

	typedef enum logic [2:0] {
		XF_LIN = 3'd0,
		XF_ELL = 3'd1,
		XF_GAU = 3'd2,
		XF_HYP = 3'd3
	} xf_op_t;

	typedef struct packed {
		logic        start;
		xf_op_t      op;
		logic [15:0] a;     // |d| saturated at 2.0
	} xf_req_t;

	function automatic logic signed [15:0] gauss_val(input logic [4:0] k);
		logic signed [15:0] g;
		case (k)
			5'd0:    g = 16'sd16384;
			5'd1:    g = 16'sd15801;
			5'd2:    g = 16'sd14158;
			5'd3:    g = 16'sd11739;
			5'd4:    g = 16'sd8928;
			5'd5:    g = 16'sd6111;
			5'd6:    g = 16'sd3587;
			5'd7:    g = 16'sd1536;
			5'd8:    g = 16'sd0;
			5'd9:    g = -16'sd1057;
			5'd10:   g = -16'sd1732;
			5'd11:   g = -16'sd2132;
			5'd12:   g = -16'sd2354;
			5'd13:   g = -16'sd2468;
			5'd14:   g = -16'sd2523;
			5'd15:   g = -16'sd2548;
			default: g = -16'sd2558;
		endcase
		return g;
	endfunction

endpackage

/* sv/window_feature_similarity_core.sv */
// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+----------------------------------
// sample   | in        | sample_valid / sample_ready | sample
// result   | out       | result_valid / result_ready | score, out_col, out_row, frame_last
// config   | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// The front takes one sample per clock while the job queue has room. The back pops a job,
// writes the line store, and for a full window walks the N = WIN_W*WIN_H
// taps, one line-store read and one transfer evaluation at a time; the elliptic
// and hyperbola transfers run in the serial sqrt/divide unit, and the back takes
// no new job until the window is done.
// Reset clears counters and control and sets config to its defaults; the line store is not cleared.
// A stalled result holds in the output register; the back waits, the queue fills,
// then sample_ready drops.
module window_feature_similarity_core
	import wfs_pkg::*;
#(
	parameter int WIN_W     = DEF_WIN_W,
	parameter int WIN_H     = DEF_WIN_H,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [15:0]    sample,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	output logic signed [15:0]    score,
	output logic [9:0]            out_col,
	output logic [9:0]            out_row,
	output logic                  frame_last,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [1:0]  tf_mode_q;
	logic [10:0] frame_width_q;
	logic [10:0] frame_height_q;
	feat_t       feat_q;

	// front to back job queue
	job_t        fjob, bjob;
	logic        push, pop, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_mode_q      <= MODE_LINEAR;
			frame_width_q  <= 11'd1024;
			frame_height_q <= 11'd1024;
			feat_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TF_MODE:      tf_mode_q      <= cfg_data[1:0];
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[10:0];
				CFG_FEAT_0:       feat_q[0]      <= cfg_data;
				CFG_FEAT_1:       feat_q[1]      <= cfg_data;
				CFG_FEAT_2:       feat_q[2]      <= cfg_data;
				CFG_FEAT_3:       feat_q[3]      <= cfg_data;
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// front: position tracking, window classification
	wfs_front #(
		.WIN_W     (WIN_W),
		.WIN_H     (WIN_H),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.job          (fjob),
		.job_push     (push),
		.job_full     (full)
	);

	wfs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fjob),
		.full   (full),
		.pop    (pop),
		.dout   (bjob),
		.empty  (empty)
	);

	// back: line store, per-tap transfer, window mean, output register
	wfs_back #(
		.WIN_W     (WIN_W),
		.WIN_H     (WIN_H),
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (bjob),
		.job_empty    (empty),
		.job_pop      (pop),
		.tf_mode      (tf_mode_q),
		.feat         (feat_q),
		.score        (score),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

/* sv/wfs_fifo.sv */
module wfs_fifo
	import wfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

/* sv/wfs_front.sv */
module wfs_front
	import wfs_pkg::*;
#(
	parameter int WIN_W     = DEF_WIN_W,
	parameter int WIN_H     = DEF_WIN_H,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] sample,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic [10:0]        frame_width,
	input  logic [10:0]        frame_height,
	output job_t               job,
	output logic               job_push,
	input  logic               job_full
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int XW   = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int RM_W = (WIN_H > 1) ? $clog2(WIN_H) : 1;

	logic [CW-1:0]   col_q;
	logic [9:0]      row_q;
	logic [RM_W-1:0] rm_q;

	logic [XW-1:0]   wc, col1, fw_x;
	logic [10:0]     hc, row1;
	logic            acc;

	always_comb begin
		fw_x = XW'(frame_width);
		if (frame_width == '0) begin
			wc = XW'(1);
		end else if (fw_x > XW'(MAX_WIDTH)) begin
			wc = XW'(MAX_WIDTH);
		end else begin
			wc = fw_x;
		end
		if (frame_height == '0) begin
			hc = 11'd1;
		end else if (frame_height > 11'(MAX_HEIGHT)) begin
			hc = 11'(MAX_HEIGHT);
		end else begin
			hc = frame_height;
		end
		col1 = XW'(col_q) + XW'(1);
		row1 = 11'(row_q) + 11'd1;
	end

	assign sample_ready = !job_full;
	assign acc          = sample_valid && sample_ready;
	assign job_push     = acc;

	always_comb begin
		job.sample = sample;
		job.col    = COL_W'(col_q);
		job.rm     = 2'(rm_q);
		job.c0     = 10'(col1 - XW'(WIN_W));
		job.r0     = 10'(row1 - 11'(WIN_H));
		job.emit   = (col1 >= XW'(WIN_W)) && (row1 >= 11'(WIN_H));
		job.last   = (col1 == wc) && (row1 == hc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rm_q  <= '0;
		end else if (acc) begin
			if (col1 >= wc) begin
				col_q <= '0;
				if (row1 >= hc) begin
					row_q <= '0;
					rm_q  <= '0;
				end else begin
					row_q <= row1[9:0];
					rm_q  <= (rm_q == RM_W'(WIN_H - 1)) ? '0 : rm_q + 1'b1;
				end
			end else begin
				col_q <= col1[CW-1:0];
			end
		end
	end

endmodule

/* sv/wfs_xfer.sv */
module wfs_xfer
	import wfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  xf_req_t            req,
	output logic               busy,
	output logic signed [15:0] res
);

	logic               busy_q, neg_q;
	xf_op_t             op_q;
	logic [4:0]         cnt_q;
	logic [28:0]        v_q, r_q, bit_q;
	logic [15:0]        rem_q, den_q;
	logic signed [28:0] p0_q, p1_q;
	logic signed [15:0] res_q;

	logic signed [16:0] t, hd;
	logic signed [33:0] sq;
	logic [16:0]        hmag;
	logic [15:0]        hden;
	logic [28:0]        hdiv;
	logic [4:0]         gk;
	logic [10:0]        gf;
	logic signed [15:0] g0, g1;
	logic signed [28:0] p0_d, p1_d, gs;
	logic [16:0]        rem_sh;
	logic               geq, sq_ok;
	logic [15:0]        rem_n;
	logic [28:0]        v_div, v_sq, r_sq;
	logic [29:0]        rb;
	logic signed [15:0] g_res;

	assign busy = busy_q;
	assign res  = res_q;

	always_comb begin
		t    = $signed({1'b0, req.a}) - 17'sd16384;
		sq   = t * t;
		hd   = 17'sd16384 - $signed({1'b0, req.a});
		hmag = hd[16] ? 17'(-hd) : 17'(hd);
		hden = 16'(17'd16384 + {1'b0, req.a});
		hdiv = {hmag[14:0], 14'b0} + 29'(hden >> 1);
		gk   = req.a[15:11];
		gf   = req.a[10:0];
		g0   = gauss_val(gk);
		g1   = gauss_val(gk + 5'd1);
		p0_d = g0 * $signed({2'b0, 12'd2048 - {1'b0, gf}});
		p1_d = g1 * $signed({3'b0, gf});
		// restoring divide step
		rem_sh = {rem_q, v_q[28]};
		geq    = rem_sh >= {1'b0, den_q};
		rem_n  = geq ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
		v_div  = {v_q[27:0], geq};
		// square root step, two radicand bits at a time
		rb    = 30'(r_q) + 30'(bit_q);
		sq_ok = 30'(v_q) >= rb;
		v_sq  = sq_ok ? 29'(30'(v_q) - rb) : v_q;
		r_sq  = sq_ok ? (r_q >> 1) + bit_q : r_q >> 1;
		// table interpolation, round half up
		gs    = p0_q + p1_q;
		g_res = 16'((gs + 29'sd1024) >>> 11);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= XF_LIN;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			p0_q   <= '0;
			p1_q   <= '0;
			res_q  <= '0;
		end else if (req.start) begin
			op_q <= req.op;
			unique case (req.op)
				XF_LIN: begin
					res_q  <= 16'(17'sd16384 - $signed({1'b0, req.a}));
					busy_q <= 1'b0;
				end
				XF_ELL: begin
					v_q    <= 29'h1000_0000 - sq[28:0];
					r_q    <= '0;
					bit_q  <= 29'h1000_0000;
					cnt_q  <= 5'd15;
					busy_q <= 1'b1;
				end
				XF_GAU: begin
					p0_q   <= p0_d;
					p1_q   <= p1_d;
					cnt_q  <= 5'd1;
					busy_q <= 1'b1;
				end
				XF_HYP: begin
					v_q    <= hdiv;
					rem_q  <= '0;
					den_q  <= hden;
					neg_q  <= hd[16];
					cnt_q  <= 5'd29;
					busy_q <= 1'b1;
				end
				default: begin
					res_q  <= '0;
					busy_q <= 1'b0;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				XF_ELL: begin
					v_q   <= v_sq;
					r_q   <= r_sq;
					bit_q <= bit_q >> 2;
					if (cnt_q == 5'd1) begin
						res_q <= 16'(17'sd16384 - $signed({1'b0, r_sq[15:0]}));
					end
				end
				XF_GAU: begin
					res_q <= g_res;
				end
				XF_HYP: begin
					v_q   <= v_div;
					rem_q <= rem_n;
					if (cnt_q == 5'd1) begin
						res_q <= neg_q ? 16'(-$signed({1'b0, v_div[15:0]}))
							: $signed(v_div[15:0]);
					end
				end
				default: begin
					res_q <= '0;
				end
			endcase
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/wfs_back.sv */
module wfs_back
	import wfs_pkg::*;
#(
	parameter int WIN_W     = DEF_WIN_W,
	parameter int WIN_H     = DEF_WIN_H,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  job_t               job,
	input  logic               job_empty,
	output logic               job_pop,
	input  logic [1:0]         tf_mode,
	input  feat_t              feat,
	output logic signed [15:0] score,
	output logic [9:0]         out_col,
	output logic [9:0]         out_row,
	output logic               frame_last,
	output logic               result_valid,
	input  logic               result_ready
);

	localparam int N     = WIN_W * WIN_H;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int DEPTH = WIN_H * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int RM_W  = (WIN_H > 1) ? $clog2(WIN_H) : 1;
	localparam int FX_W  = (WIN_W > 1) ? $clog2(WIN_W) : 1;
	localparam int SW    = 16 + $clog2(N) + 2;
	// mean by reciprocal multiply; exact for magnitudes below 2^19
	localparam int          RCP_SH = 24;
	localparam logic [24:0] RCP    = 25'((2 ** RCP_SH + N - 1) / N);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WRITE = 6'b000010,
		ST_READ  = 6'b000100,
		ST_DATA  = 6'b001000,
		ST_XFER  = 6'b010000,
		ST_MEAN  = 6'b100000
	} st_t;

	st_t                st_q;
	job_t               job_q;
	logic [15:0]        mem [DEPTH];
	logic [15:0]        rdata_q;
	logic [FX_W-1:0]    fx_q;
	logic [RM_W-1:0]    prow_q;
	logic [CW-1:0]      ccol_q, cstart;
	logic [3:0]         idx_q;
	logic signed [SW-1:0] sum_q, sum_n, sum_abs;
	logic               out_valid_q, out_free;

	xf_req_t            xreq;
	logic               xf_busy;
	logic signed [15:0] xf_res;

	logic [AW-1:0]      waddr, raddr;
	logic [15:0]        coef;
	logic signed [16:0] d, dabs;
	logic [15:0]        a;
	xf_op_t             mode_op;
	logic               last_elem;
	logic [19:0]        mean_mag;
	logic [44:0]        mean_prod;
	logic signed [15:0] mean_res;

	wfs_xfer u_xfer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (xreq),
		.busy   (xf_busy),
		.res    (xf_res)
	);

	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || result_ready;
	assign job_pop      = (st_q == ST_IDLE) && !job_empty;

	always_comb begin
		waddr  = AW'(32'(job_q.rm) * MAX_WIDTH + 32'(job_q.col));
		raddr  = AW'(32'(prow_q) * MAX_WIDTH + 32'(ccol_q));
		cstart = CW'(job_q.col) - CW'(WIN_W - 1);
		coef   = feat[idx_q[3:2]][{idx_q[1:0], 4'b0} +: 16];
		d      = $signed({rdata_q[15], rdata_q}) - $signed({coef[15], coef});
		dabs   = d[16] ? -d : d;
		a      = (17'(dabs) > 17'd32768) ? 16'd32768 : dabs[15:0];
		unique case (tf_mode)
			MODE_LINEAR:    mode_op = XF_LIN;
			MODE_ELLIPTIC:  mode_op = XF_ELL;
			MODE_GAUSSIAN:  mode_op = XF_GAU;
			MODE_HYPERBOLA: mode_op = XF_HYP;
			default:        mode_op = XF_LIN;
		endcase
		last_elem = (idx_q == 4'(N - 1));
		sum_n     = sum_q + SW'(xf_res);
		// window mean, rounded half away from zero
		sum_abs   = sum_q[SW-1] ? -sum_q : sum_q;
		mean_mag  = 20'(sum_abs) + 20'(N / 2);
		mean_prod = 45'(mean_mag) * 45'(RCP);
		mean_res  = sum_q[SW-1] ? -$signed({1'b0, mean_prod[RCP_SH +: 15]})
			: $signed({1'b0, mean_prod[RCP_SH +: 15]});

		xreq.start = (st_q == ST_DATA);
		xreq.op    = mode_op;
		xreq.a     = a;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WRITE) begin
			mem[waddr] <= job_q.sample;
		end
		if (st_q == ST_READ) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			job_q       <= '0;
			fx_q        <= '0;
			prow_q      <= '0;
			ccol_q      <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			score       <= '0;
			out_col     <= '0;
			out_row     <= '0;
			frame_last  <= 1'b0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!job_empty) begin
						job_q <= job;
						st_q  <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					fx_q   <= '0;
					idx_q  <= '0;
					sum_q  <= '0;
					ccol_q <= cstart;
					prow_q <= (RM_W'(job_q.rm) == RM_W'(WIN_H - 1)) ? '0
						: RM_W'(job_q.rm) + 1'b1;
					st_q   <= job_q.emit ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					st_q <= ST_DATA;
				end
				ST_DATA: begin
					st_q <= ST_XFER;
				end
				ST_XFER: begin
					if (!xf_busy) begin
						sum_q <= sum_n;
						idx_q <= idx_q + 4'd1;
						if (last_elem) begin
							st_q <= ST_MEAN;
						end else begin
							st_q <= ST_READ;
							if (fx_q == FX_W'(WIN_W - 1)) begin
								fx_q   <= '0;
								ccol_q <= cstart;
								prow_q <= (prow_q == RM_W'(WIN_H - 1)) ? '0 : prow_q + 1'b1;
							end else begin
								fx_q   <= fx_q + 1'b1;
								ccol_q <= ccol_q + 1'b1;
							end
						end
					end
				end
				ST_MEAN: begin
					if (out_free) begin
						score       <= mean_res;
						out_col     <= job_q.c0;
						out_row     <= job_q.r0;
						frame_last  <= job_q.last;
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for window_feature_similarity_core.
// A driver pushes samples from a pending queue in bursts with random gaps;
// every accepted item goes through a behavioral predictor that mirrors the
// line buffer, the 3x3 window and the four transfer functions.
// Window results are queued in raster order and the monitor compares each
// accepted result field by field with the oldest one. The receiver stalls on
// a pattern that changes now and then.
// Registers are only rewritten while the core is drained, at frame boundaries.
module tb_top;
	import wfs_pkg::*;

	localparam int WW      = DEF_WIN_W;
	localparam int WH      = DEF_WIN_H;
	localparam int MAXW    = DEF_MAX_WIDTH;
	localparam int TAPS    = WW * WH;
	// covers the slowest windows (hyperbola): queue of two plus the one in work
	localparam int SETTLE  = 1200;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic signed [15:0] score;
		logic [9:0]         col;
		logic [9:0]         row;
		logic               last;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic signed [15:0]    sample = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic signed [15:0]    score;
	logic [9:0]            out_col;
	logic [9:0]            out_row;
	logic                  frame_last;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	window_feature_similarity_core dut (
		.clk(clk), .arst_n(arst_n),
		.sample(sample), .sample_valid(sample_valid), .sample_ready(sample_ready),
		.score(score), .out_col(out_col), .out_row(out_row), .frame_last(frame_last),
		.result_valid(result_valid), .result_ready(result_ready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor state
	logic [15:0]  line_mem[WH*MAXW];
	int unsigned  col_ctr, row_ctr;
	logic [1:0]   cur_mode;
	logic [10:0]  cur_width, cur_height;
	feat_t        cur_feat;
	int           bell_tab[17] = '{16384, 15801, 14158, 11739, 8928, 6111, 3587, 1536, 0,
		-1057, -1732, -2132, -2354, -2468, -2523, -2548, -2558};

	logic signed [15:0] pending_samples[$];
	window_result_t     expected_windows[$];
	int                 mismatches = 0;
	int                 items_queued = 0;

	function automatic int round_div(longint num, longint den);
		if (num >= 0)
			return int'((num + den / 2) / den);
		return int'(-((-num + den / 2) / den));
	endfunction

	function automatic int unsigned root_floor(int unsigned v);
		int unsigned r, b;
		r = 0;
		b = 32'd1 << 30;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int transfer_value(int d);
		int a, t, k, f, s;
		a = (d < 0) ? -d : d;
		if (a > 32768)
			a = 32768;
		case (cur_mode)
			MODE_LINEAR: return 16384 - a;
			MODE_ELLIPTIC: begin
				t = a - 16384;
				return 16384 - int'(root_floor((32'd1 << 28) - t * t));
			end
			MODE_GAUSSIAN: begin
				k = a >> 11;
				f = a & 2047;
				if (k >= 16)
					return bell_tab[16];
				s = bell_tab[k] * (2048 - f) + bell_tab[k + 1] * f;
				// s + 2^26 is always positive here
				return ((s + (1 << 26) + 1024) >> 11) - (1 << 15);
			end
			default: return round_div(longint'(16384 - a) * 16384, longint'(16384 + a));
		endcase
	endfunction

	function automatic int feature_coef(int i);
		return int'($signed(cur_feat[i >> 2][(i & 3) * 16 +: 16]));
	endfunction

	// one accepted sample: update line buffer, maybe queue a window result
	task automatic absorb_sample(logic signed [15:0] s);
		int unsigned w, h, col, row, c0, r0;
		int sum;
		window_result_t res;
		w = (cur_width == 0) ? 1 : (cur_width > MAXW ? MAXW : cur_width);
		h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height);
		col = col_ctr % MAXW;
		row = row_ctr;
		line_mem[(row % WH) * MAXW + col] = s;
		if (col + 1 >= WW && row + 1 >= WH) begin
			c0 = col + 1 - WW;
			r0 = row + 1 - WH;
			sum = 0;
			for (int fy = 0; fy < WH; fy++)
				for (int fx = 0; fx < WW; fx++)
					sum += transfer_value(
						int'($signed(line_mem[((r0 + fy) % WH) * MAXW + ((c0 + fx) % MAXW)]))
						- feature_coef(fx + fy * WW));
			res.score = 16'(round_div(sum, TAPS));
			res.col   = c0[9:0];
			res.row   = r0[9:0];
			res.last  = (col == w - 1 && row == h - 1);
			expected_windows.push_back(res);
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h)
				row = 0;
		end
		col_ctr = col;
		row_ctr = row;
	endtask

	// driver: bursts of random length, random gaps between them
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			nv = sample_valid;
			if (sample_valid && sample_ready)
				absorb_sample(sample);
			if (!sample_valid || sample_ready) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					sample <= pending_samples.pop_front();
					nv = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 64);
						// a good share of bursts run back to back
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			sample_valid <= nv;
		end
	end

	// receiver stall pattern, switched every so often
	int stall_kind = 0;
	int stall_left = 0;
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 400);
			end
			stall_left--;
			stall_phase = (stall_phase + 1) % 5;
			case (stall_kind)
				0: result_ready <= 1'b1;
				1: result_ready <= $urandom_range(0, 1);
				2: result_ready <= ($urandom_range(0, 7) == 0);
				default: result_ready <= (stall_phase != 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: score %0d col %0d row %0d last %0b",
						score, out_col, out_row, frame_last);
			end else begin
				want = expected_windows.pop_front();
				if (score !== want.score || out_col !== want.col ||
						out_row !== want.row || frame_last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp score %0d col %0d row %0d last %0b, %s",
							want.score, want.col, want.row, want.last,
							$sformatf("got score %0d col %0d row %0d last %0b",
								score, out_col, out_row, frame_last));
				end
			end
		end
	end

	// watchdog on handshake activity
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("window_feature_similarity_core verification failed");
			$finish;
		end
	end

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TF_MODE:      cur_mode = val[1:0];
			CFG_FRAME_WIDTH:  cur_width = val[10:0];
			CFG_FRAME_HEIGHT: cur_height = val[10:0];
			CFG_FEAT_0:       cur_feat[0] = val;
			CFG_FEAT_1:       cur_feat[1] = val;
			CFG_FEAT_2:       cur_feat[2] = val;
			default:          cur_feat[3] = val;
		endcase
	endtask

	// wait for the core to drain, then let any no-result item finish
	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_valid || expected_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic setup(logic [1:0] mode, logic [10:0] w, logic [10:0] h, feat_t f);
		wait_drained();
		reg_write(CFG_TF_MODE, 64'(mode));
		reg_write(CFG_FRAME_WIDTH, 64'(w));
		reg_write(CFG_FRAME_HEIGHT, 64'(h));
		reg_write(CFG_FEAT_0, f[0]);
		reg_write(CFG_FEAT_1, f[1]);
		reg_write(CFG_FEAT_2, f[2]);
		reg_write(CFG_FEAT_3, f[3]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample();
		int c;
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2, 3: begin
				// near a coefficient, so d sits close to zero
				c = feature_coef($urandom_range(0, TAPS - 1)) + $urandom_range(0, 64) - 32;
				if (c > 16384) c = 16384;
				if (c < -16384) c = -16384;
				return 16'(c);
			end
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic int eff_size(logic [10:0] v, int cap);
		return (v == 0) ? 1 : (v > cap ? cap : int'(v));
	endfunction

	task automatic queue_frames(int nframes);
		int n;
		n = nframes * eff_size(cur_width, MAXW) * eff_size(cur_height, MAX_HEIGHT);
		repeat (n) begin
			pending_samples.push_back(pick_sample());
			items_queued++;
		end
	endtask

	function automatic feat_t rand_feat();
		feat_t f;
		for (int i = 0; i < 4; i++)
			f[i] = {$urandom, $urandom};
		return f;
	endfunction

	initial begin
		feat_t f;
		logic signed [15:0] edge_vals[9];
		edge_vals = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1,
			16'sd8192, -16'sd8192, 16'sd16383, -16'sd16383};
		cur_mode = MODE_LINEAR;
		cur_width = 11'd1024;
		cur_height = 11'd1024;
		cur_feat = '0;
		col_ctr = 0;
		row_ctr = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: one 3x3 window per transfer function on extreme samples
		for (int m = 0; m < 4; m++) begin
			f = '0;
			if (m == 2)
				f = {64'h8000_7FFF_C000_4000, 64'h8000_7FFF_C000_4000,
					64'h8000_7FFF_C000_4000, 64'h8000_7FFF_C000_4000};
			setup(2'(m), 11'd3, 11'd3, f);
			foreach (edge_vals[i]) begin
				pending_samples.push_back(edge_vals[i]);
				items_queued++;
			end
		end
		// zero width counts as one column; window never fits
		setup(MODE_HYPERBOLA, 11'd0, 11'd4, '1);
		queue_frames(1);
		// zero height counts as one row
		setup(MODE_ELLIPTIC, 11'd3, 11'd0, '0);
		queue_frames(1);
		// a frame narrower than the window: two columns, five rows
		setup(MODE_GAUSSIAN, 11'd2, 11'd5, rand_feat());
		queue_frames(1);

		// widest line (register above the limit saturates); the frames after it
		// show whether the column wrapped at the right place
		setup(MODE_LINEAR, 11'd2047, 11'd1, rand_feat());
		queue_frames(1);

		// random frames, mostly small
		while (items_queued < 1450) begin
			setup(2'($urandom_range(0, 3)),
				11'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(3, 10)),
				11'($urandom_range(1, 7)), rand_feat());
			queue_frames($urandom_range(1, 3));
		end

		wait_drained();
		if (mismatches == 0)
			$display("window_feature_similarity_core verification clean");
		else
			$display("window_feature_similarity_core verification failed");
		$finish;
	end

endmodule
